// ===== hw/rtl/lpht_pkg.sv =====
// Shared constants for the linear-probe hash table core: field widths of the
// stream payloads, result status codes and the load limit register.
// No dependencies.
`timescale 1ns / 1ps

package lpht_pkg;

	localparam int HASH_W      = 64;
	localparam int KEY_IN_W    = 64;
	localparam int LEN_W       = 4;
	localparam int PUT_W       = 32;
	localparam int STATUS_W    = 3;
	localparam int READ_W      = 32;
	localparam int COUNT_W     = 11;
	localparam int LIMIT_W     = 10;

	localparam int IN_DATA_W   = 168;
	localparam int OUT_DATA_W  = 48;

	localparam int HASH_LSB    = 0;
	localparam int KEY_LSB     = HASH_LSB + HASH_W;
	localparam int LEN_LSB     = KEY_LSB + KEY_IN_W;
	localparam int PUT_LSB     = LEN_LSB + LEN_W;
	localparam int IN_USED_W   = PUT_LSB + PUT_W;

	localparam int READ_LSB    = 0;
	localparam int COUNT_LSB   = READ_LSB + READ_W;
	localparam int OUT_USED_W  = COUNT_LSB + COUNT_W;

	localparam int LOAD_NUM    = 7;
	localparam int LOAD_DEN    = 10;
	localparam int LIMIT_MAX   = 1023;

	localparam logic ACT_PUT = 1'b0;
	localparam logic ACT_GET = 1'b1;

	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

	localparam int REG_LOAD_LIMIT = 0;

endpackage

// ===== hw/rtl/lpht_ram.sv =====
// Generic single-port RAM with one address per cycle and registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== hw/rtl/linear_probe_hash_table_core.sv =====
// Linear-probe hash table core: sequencer, request registers and slot store.
// Depends on lpht_pkg and lpht_ram.
`timescale 1ns / 1ps

// Each request is a put or a get of one key with a precomputed hash. After
// reset the core clears every slot of the slot store and accepts no
// request during that time; the load limit register can still be written.
// A request is then accepted in S_IDLE, probes slots in S_CHECK and waits in
// S_DONE until the output register is free; the single port of the slot store
// reads or writes one slot a cycle, so slots are probed one at a time.
// The next request is accepted while a finished result waits.

module linear_probe_hash_table_core #(
	parameter int SLOTS       = 1024,
	parameter int KEY_BYTES   = 8,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// key_hash[63:0], key_bytes[127:64], key_length[131:128], put_value[163:132]
	input  logic [lpht_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// action[0]
	input  logic                             s_axis_tuser,

	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// read_value[31:0], entry_count[42:32]
	output logic [lpht_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// status[2:0]
	output logic [lpht_pkg::STATUS_W-1:0]    m_axis_tuser,

	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [2:0]                       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	localparam int ADDR_W   = $clog2(SLOTS);
	localparam int KEY_W    = 8 * KEY_BYTES;
	localparam int VIN_W    = (VALUE_WIDTH < lpht_pkg::PUT_W) ? VALUE_WIDTH : lpht_pkg::PUT_W;
	localparam int VOUT_W   = (VALUE_WIDTH < lpht_pkg::READ_W) ? VALUE_WIDTH : lpht_pkg::READ_W;

	localparam int E_VAL_LSB  = 0;
	localparam int E_KEY_LSB  = E_VAL_LSB + VALUE_WIDTH;
	localparam int E_HASH_LSB = E_KEY_LSB + KEY_W;
	localparam int E_LEN_LSB  = E_HASH_LSB + lpht_pkg::HASH_W;
	localparam int E_USED     = E_LEN_LSB + lpht_pkg::LEN_W;
	localparam int ENT_W      = E_USED + 1;

	localparam int LIM_RST_I  = (SLOTS * lpht_pkg::LOAD_NUM) / lpht_pkg::LOAD_DEN;
	localparam int LIM_RST_C  = (LIM_RST_I > lpht_pkg::LIMIT_MAX) ? lpht_pkg::LIMIT_MAX
	                                                                : LIM_RST_I;
	localparam int LIM_CAP_I  = (SLOTS - 1 > lpht_pkg::LIMIT_MAX) ? lpht_pkg::LIMIT_MAX
	                                                                : SLOTS - 1;
	localparam logic [lpht_pkg::LIMIT_W-1:0] LIM_RST = lpht_pkg::LIMIT_W'(LIM_RST_C);
	localparam logic [lpht_pkg::LIMIT_W-1:0] LIM_CAP = lpht_pkg::LIMIT_W'(LIM_CAP_I);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_DONE
	} state_t;

	state_t                           state_q;
	logic [ADDR_W-1:0]                clr_q;
	logic [ADDR_W-1:0]                idx_q;
	logic                             act_q;
	logic [lpht_pkg::HASH_W-1:0]      hash_q;
	logic [KEY_W-1:0]                 key_q;
	logic [lpht_pkg::LEN_W-1:0]       len_q;
	logic [VALUE_WIDTH-1:0]           val_q;
	logic [lpht_pkg::COUNT_W-1:0]     count_q;
	logic [lpht_pkg::LIMIT_W-1:0]     limit_q;
	logic [lpht_pkg::STATUS_W-1:0]    res_status_q;
	logic [lpht_pkg::READ_W-1:0]      res_value_q;
	logic                             m_valid_q;
	logic [lpht_pkg::STATUS_W-1:0]    m_status_q;
	logic [lpht_pkg::READ_W-1:0]      m_value_q;
	logic [lpht_pkg::COUNT_W-1:0]     m_count_q;

	logic [KEY_W-1:0]                 key_in;
	logic [VALUE_WIDTH-1:0]           val_in;
	logic [lpht_pkg::LEN_W-1:0]       len_in;
	logic [lpht_pkg::LIMIT_W-1:0]     eff_limit;
	logic                             accept;
	logic                             cfg_write;
	logic                             slot_used;
	logic                             slot_match;
	logic                             can_insert;
	logic                             done_probe;
	logic                             do_write;
	logic [lpht_pkg::READ_W-1:0]      slot_value;
	logic                             ram_we;
	logic [ADDR_W-1:0]                ram_addr;
	logic [ENT_W-1:0]                 ram_wdata;
	logic [ENT_W-1:0]                 ram_rdata;

	assign pready        = 1'b1;
	assign cfg_write     = psel & penable & pwrite & pready;
	assign prdata        = (paddr[2] == 1'(lpht_pkg::REG_LOAD_LIMIT))
	                       ? {{(32 - lpht_pkg::LIMIT_W){1'b0}}, limit_q} : 32'd0;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid & s_axis_tready;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = {{(lpht_pkg::OUT_DATA_W - lpht_pkg::OUT_USED_W){1'b0}},
	                        m_count_q, m_value_q};

	assign len_in = s_axis_tdata[lpht_pkg::LEN_LSB +: lpht_pkg::LEN_W];

	always_comb begin
		for (int b = 0; b < KEY_BYTES; b++) begin
			key_in[b*8 +: 8] = (len_in > lpht_pkg::LEN_W'(b))
			                   ? s_axis_tdata[lpht_pkg::KEY_LSB + b*8 +: 8] : 8'd0;
		end
	end

	always_comb begin
		val_in = '0;
		for (int i = 0; i < VIN_W; i++) begin
			val_in[i] = s_axis_tdata[lpht_pkg::PUT_LSB + i];
		end
	end

	always_comb begin
		slot_value = '0;
		for (int i = 0; i < VOUT_W; i++) begin
			slot_value[i] = ram_rdata[E_VAL_LSB + i];
		end
	end

	always_comb begin
		if (limit_q == '0) begin
			eff_limit = lpht_pkg::LIMIT_W'(1);
		end else if (limit_q > LIM_CAP) begin
			eff_limit = LIM_CAP;
		end else begin
			eff_limit = limit_q;
		end
	end

	assign slot_used  = ram_rdata[E_USED];
	assign slot_match = slot_used
	                    && (ram_rdata[E_HASH_LSB +: lpht_pkg::HASH_W] == hash_q)
	                    && (ram_rdata[E_LEN_LSB +: lpht_pkg::LEN_W] == len_q)
	                    && (ram_rdata[E_KEY_LSB +: KEY_W] == key_q);
	assign can_insert = (act_q == lpht_pkg::ACT_PUT)
	                    && (count_q < {{(lpht_pkg::COUNT_W - lpht_pkg::LIMIT_W){1'b0}},
	                                   eff_limit});
	assign done_probe = !slot_used || slot_match;
	assign do_write   = (state_q == S_CHECK)
	                    && ((!slot_used && can_insert)
	                        || (slot_match && act_q == lpht_pkg::ACT_PUT));

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = {1'b1, len_q, hash_q, key_q, val_q};
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			S_IDLE: begin
				ram_addr = s_axis_tdata[lpht_pkg::HASH_LSB +: ADDR_W];
			end
			S_CHECK: begin
				ram_we   = do_write;
				ram_addr = done_probe ? idx_q : idx_q + ADDR_W'(1);
			end
			default: begin
				ram_addr = idx_q;
			end
		endcase
	end

	lpht_ram #(
		.WIDTH (ENT_W),
		.DEPTH (SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			count_q   <= '0;
			limit_q   <= LIM_RST;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_write && paddr[2] == 1'(lpht_pkg::REG_LOAD_LIMIT)) begin
				limit_q <= pwdata[lpht_pkg::LIMIT_W-1:0];
			end
			if (m_valid_q && m_axis_tready && state_q != S_DONE) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						act_q   <= s_axis_tuser;
						hash_q  <= s_axis_tdata[lpht_pkg::HASH_LSB +: lpht_pkg::HASH_W];
						key_q   <= key_in;
						len_q   <= len_in;
						val_q   <= val_in;
						idx_q   <= s_axis_tdata[lpht_pkg::HASH_LSB +: ADDR_W];
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (!slot_used) begin
						res_value_q <= '0;
						if (act_q == lpht_pkg::ACT_GET) begin
							res_status_q <= lpht_pkg::ST_NOT_FOUND;
						end else if (can_insert) begin
							res_status_q <= lpht_pkg::ST_INSERTED;
							count_q      <= count_q + lpht_pkg::COUNT_W'(1);
						end else begin
							res_status_q <= lpht_pkg::ST_FULL;
						end
						state_q <= S_DONE;
					end else if (slot_match) begin
						if (act_q == lpht_pkg::ACT_GET) begin
							res_status_q <= lpht_pkg::ST_FOUND;
							res_value_q  <= slot_value;
						end else begin
							res_status_q <= lpht_pkg::ST_UPDATED;
							res_value_q  <= '0;
						end
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + ADDR_W'(1);
					end
				end
				S_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q  <= 1'b1;
						m_status_q <= res_status_q;
						m_value_q  <= res_value_q;
						m_count_q  <= count_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for linear_probe_hash_table_core: streams puts and gets,
// predicts every result with a scoreboard that mirrors the slot store, and checks them.
// Depends on lpht_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

	localparam int SLOTS       = 1024;
	localparam int KEY_BYTES   = 8;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = $clog2(SLOTS);
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 230;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 20000;

	typedef struct packed {
		logic [lpht_pkg::STATUS_W-1:0] status;
		logic [lpht_pkg::READ_W-1:0]   read_value;
		logic [lpht_pkg::COUNT_W-1:0]  entry_count;
	} table_result_t;

	typedef struct {
		logic [lpht_pkg::HASH_W-1:0]   hash;
		logic [lpht_pkg::KEY_IN_W-1:0] bytes;
		logic [lpht_pkg::LEN_W-1:0]    len;
	} key_t;

	class hash_table_scoreboard;
		bit                            slot_used [SLOTS];
		logic [lpht_pkg::HASH_W-1:0]   slot_hash [SLOTS];
		logic [lpht_pkg::KEY_IN_W-1:0] slot_key [SLOTS];
		logic [lpht_pkg::LEN_W-1:0]    slot_len [SLOTS];
		logic [lpht_pkg::PUT_W-1:0]    slot_value [SLOTS];
		int unsigned                   occupied;
		logic [lpht_pkg::LIMIT_W-1:0]  load_limit;
		table_result_t                 pending_results [$];
		int                            errors;

		function new();
			int d;
			foreach (slot_used[i])
				slot_used[i] = 1'b0;
			occupied = 0;
			errors = 0;
			d = SLOTS * lpht_pkg::LOAD_NUM / lpht_pkg::LOAD_DEN;
			if (d > lpht_pkg::LIMIT_MAX)
				d = lpht_pkg::LIMIT_MAX;
			load_limit = d[lpht_pkg::LIMIT_W-1:0];
		endfunction

		static function logic [lpht_pkg::KEY_IN_W-1:0] valid_key_mask(
				logic [lpht_pkg::LEN_W-1:0] len);
			int n;
			n = (len > KEY_BYTES) ? KEY_BYTES : len;
			if (n >= 8)
				return '1;
			return (64'd1 << (8 * n)) - 64'd1;
		endfunction

		function int unsigned effective_limit();
			int unsigned lim;
			lim = 32'(load_limit);
			if (lim < 1)
				lim = 1;
			if (lim > SLOTS - 1)
				lim = SLOTS - 1;
			return lim;
		endfunction

		function table_result_t lookup_or_store(logic act, logic [lpht_pkg::HASH_W-1:0] h,
				logic [lpht_pkg::KEY_IN_W-1:0] k, logic [lpht_pkg::LEN_W-1:0] len,
				logic [lpht_pkg::PUT_W-1:0] v);
			table_result_t r;
			logic [lpht_pkg::KEY_IN_W-1:0] key;
			logic [IDX_W-1:0] idx;
			key = k & valid_key_mask(len);
			idx = h[IDX_W-1:0];
			r.status = (act == lpht_pkg::ACT_GET) ? lpht_pkg::ST_NOT_FOUND : lpht_pkg::ST_FULL;
			r.read_value = '0;
			for (int probe = 0; probe < SLOTS; probe++) begin
				if (!slot_used[idx]) begin
					if (act == lpht_pkg::ACT_PUT && occupied < effective_limit()) begin
						slot_used[idx] = 1'b1;
						slot_hash[idx] = h;
						slot_key[idx] = key;
						slot_len[idx] = len;
						slot_value[idx] = v;
						occupied++;
						r.status = lpht_pkg::ST_INSERTED;
					end
					break;
				end
				if (slot_hash[idx] == h && slot_len[idx] == len && slot_key[idx] == key) begin
					if (act == lpht_pkg::ACT_GET) begin
						r.read_value = slot_value[idx];
						r.status = lpht_pkg::ST_FOUND;
					end else begin
						slot_value[idx] = v;
						r.status = lpht_pkg::ST_UPDATED;
					end
					break;
				end
				idx = idx + IDX_W'(1);
			end
			r.entry_count = lpht_pkg::COUNT_W'(occupied);
			return r;
		endfunction

		function void flag(string what, logic [63:0] want, logic [63:0] got);
			if (errors < 10)
				$display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
			errors++;
		endfunction

		function void note_request(logic act, logic [lpht_pkg::HASH_W-1:0] h,
				logic [lpht_pkg::KEY_IN_W-1:0] k, logic [lpht_pkg::LEN_W-1:0] len,
				logic [lpht_pkg::PUT_W-1:0] v);
			pending_results.push_back(lookup_or_store(act, h, k, len, v));
		endfunction

		function void check_response(logic [lpht_pkg::STATUS_W-1:0] status,
				logic [lpht_pkg::READ_W-1:0] rd, logic [lpht_pkg::COUNT_W-1:0] count);
			table_result_t want;
			if (pending_results.size() == 0) begin
				flag("result without a pending request", '0, 64'({status, rd, count}));
				return;
			end
			want = pending_results.pop_front();
			if (status !== want.status)
				flag("status", 64'(want.status), 64'(status));
			if (rd !== want.read_value)
				flag("read_value", 64'(want.read_value), 64'(rd));
			if (count !== want.entry_count)
				flag("entry_count", 64'(want.entry_count), 64'(count));
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [lpht_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                            s_axis_tuser = 1'b0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [lpht_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic [lpht_pkg::STATUS_W-1:0]   m_axis_tuser;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [2:0]                      paddr = '0;
	logic [31:0]                     pwdata = '0;
	logic [31:0]                     prdata;
	logic                            pready;

	hash_table_scoreboard table_sb = new();
	key_t known_keys [$];
	bit idle_on = 1'b1;
	bit long_hold_req = 1'b0;

	linear_probe_hash_table_core #(
		.SLOTS(SLOTS),
		.KEY_BYTES(KEY_BYTES),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_top (
		.clk, .arst_n,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_request(input logic act, input logic [lpht_pkg::HASH_W-1:0] h,
			input logic [lpht_pkg::KEY_IN_W-1:0] k, input logic [lpht_pkg::LEN_W-1:0] len,
			input logic [lpht_pkg::PUT_W-1:0] v);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= lpht_pkg::IN_DATA_W'({v, len, k, h});
		do @(posedge clk); while (!s_axis_tready);
		table_sb.note_request(act, h, k, len, v);
	endtask

	task automatic finish_stream();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (table_sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_cycle(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_load_limit(input logic [31:0] value);
		logic [31:0] rd;
		apb_cycle(1'b1, 3'(lpht_pkg::REG_LOAD_LIMIT * 4), value, rd);
		table_sb.load_limit = value[lpht_pkg::LIMIT_W-1:0];
		apb_cycle(1'b0, 3'(lpht_pkg::REG_LOAD_LIMIT * 4), '0, rd);
		if (rd[lpht_pkg::LIMIT_W-1:0] !== value[lpht_pkg::LIMIT_W-1:0])
			table_sb.flag("load_limit readback", 64'(value[lpht_pkg::LIMIT_W-1:0]),
				64'(rd[lpht_pkg::LIMIT_W-1:0]));
	endtask

	task automatic random_request(input int new_pct);
		key_t k;
		int r;
		int pos;
		logic act;
		logic [lpht_pkg::KEY_IN_W-1:0] keep;
		r = $urandom_range(0, 99);
		if (known_keys.size() == 0 || r < new_pct) begin
			k.hash = rand64();
			case ($urandom_range(0, 5))
				0: k.hash[IDX_W-1:0] = IDX_W'(SLOTS - 1 - $urandom_range(0, 7));
				1: begin
					if (known_keys.size() != 0)
						k.hash = known_keys[$urandom_range(0, known_keys.size() - 1)].hash;
				end
				default: ;
			endcase
			k.len = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(0, 8));
			k.bytes = rand64();
			known_keys.push_back(k);
			send_request(lpht_pkg::ACT_PUT, k.hash, k.bytes, k.len, $urandom);
		end else begin
			k = known_keys[$urandom_range(0, known_keys.size() - 1)];
			keep = hash_table_scoreboard::valid_key_mask(k.len);
			k.bytes = (k.bytes & keep) | (rand64() & ~keep);
			if (r < new_pct + 25) begin
				send_request(lpht_pkg::ACT_PUT, k.hash, k.bytes, k.len, $urandom);
			end else if (r < new_pct + 70) begin
				send_request(lpht_pkg::ACT_GET, k.hash, k.bytes, k.len, $urandom);
			end else begin
				case ($urandom_range(0, 3))
					0: k.len = k.len ^ 4'($urandom_range(1, 15));
					1: begin
						pos = $urandom_range(IDX_W, 63);
						k.hash[pos] = ~k.hash[pos];
					end
					2: begin
						pos = $urandom_range(0, 63);
						k.bytes[pos] = ~k.bytes[pos];
					end
					default: k.hash = rand64();
				endcase
				act = ($urandom_range(0, 9) < 7) ? lpht_pkg::ACT_GET : lpht_pkg::ACT_PUT;
				send_request(act, k.hash, k.bytes, k.len, $urandom);
			end
		end
	endtask

	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				table_sb.check_response(m_axis_tuser,
					m_axis_tdata[lpht_pkg::READ_LSB +: lpht_pkg::READ_W],
					m_axis_tdata[lpht_pkg::COUNT_LSB +: lpht_pkg::COUNT_W]);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 11) == 0) begin
				hold_left = $urandom_range(0, 17);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (psel && penable && pready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		int unsigned phase_limit [PHASES];
		int new_pct [PHASES];
		logic [31:0] wdata;
		phase_limit = '{40, 120, 1, 400, 0, 1023};
		new_pct = '{35, 35, 20, 35, 40, 30};
		phase_limit[4] = $urandom_range(450, 700);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Default limit, empty table: hits, updates, wrap-around and key length corners.
		send_request(lpht_pkg::ACT_GET, '0, '0, 4'd0, '1);
		send_request(lpht_pkg::ACT_PUT, '1, '1, 4'd8, '1);
		send_request(lpht_pkg::ACT_GET, '1, '1, 4'd8, '0);
		send_request(lpht_pkg::ACT_PUT, '1, '1, 4'd8, '0);
		send_request(lpht_pkg::ACT_GET, '1, '1, 4'd8, 32'h1234_5678);
		send_request(lpht_pkg::ACT_PUT, '1, 64'h0123_4567_89AB_CDEF, 4'd8, 32'h1111_1111);
		send_request(lpht_pkg::ACT_GET, '1, 64'h0123_4567_89AB_CDEF, 4'd8, '0);
		send_request(lpht_pkg::ACT_GET, '1, '1, 4'd12, '0);
		send_request(lpht_pkg::ACT_PUT, 64'h5, 64'hDEAD_BEEF_00C0_FFEE, 4'd3, 32'hA5A5_A5A5);
		send_request(lpht_pkg::ACT_GET, 64'h5, 64'h1234_5678_78C0_FFEE, 4'd3, '0);
		send_request(lpht_pkg::ACT_PUT, 64'h40, '1, 4'd15, 32'h5A5A_5A5A);
		send_request(lpht_pkg::ACT_GET, 64'h40, '1, 4'd15, '0);
		send_request(lpht_pkg::ACT_GET, 64'h40, '1, 4'd8, '0);
		send_request(lpht_pkg::ACT_PUT, '0, '0, 4'd0, '0);
		send_request(lpht_pkg::ACT_GET, '0, 64'hFFEE_DDCC_BBAA_9988, 4'd0, '1);
		send_request(lpht_pkg::ACT_PUT, 64'h8000_0000_0000_03FF, 64'h77, 4'd1, 32'h8000_0001);
		finish_stream();

		// Zero limit acts as one: new keys are refused, present keys still update.
		set_load_limit(32'd0);
		send_request(lpht_pkg::ACT_PUT, 64'h100, 64'h42, 4'd2, 32'hCAFE_0001);
		send_request(lpht_pkg::ACT_PUT, 64'h5, 64'h00C0_FFEE, 4'd3, 32'd1);
		send_request(lpht_pkg::ACT_GET, 64'h5, 64'h00C0_FFEE, 4'd3, '0);
		send_request(lpht_pkg::ACT_GET, 64'h100, 64'h42, 4'd2, '0);
		finish_stream();
		set_load_limit(32'hFFFF_FFFF);
		send_request(lpht_pkg::ACT_PUT, 64'h100, 64'h42, 4'd2, 32'hCAFE_0002);

		for (int p = 0; p < PHASES; p++) begin
			finish_stream();
			wdata = $urandom;
			wdata[lpht_pkg::LIMIT_W-1:0] = phase_limit[p][lpht_pkg::LIMIT_W-1:0];
			set_load_limit(wdata);
			if (p == 1)
				long_hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 50 == 0)
					idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
				random_request(new_pct[p]);
			end
		end
		finish_stream();
		repeat (20) @(posedge clk);

		if (table_sb.errors == 0 && table_sb.pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
